[hw/rtl/button_pad_link_controller_macros.svh]
// Assertion helpers for the checker file of the pad link controller.
`ifndef BUTTON_PAD_LINK_CONTROLLER_MACROS_SVH
`define BUTTON_PAD_LINK_CONTROLLER_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define BPLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never shows on a rising clk edge outside of reset.
`define BPLC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/bplc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bplc_pkg;

    // Request codes
    localparam logic [1:0] REQ_RX   = 2'd0;
    localparam logic [1:0] REQ_INIT = 2'd1;
    localparam logic [1:0] REQ_LED  = 2'd2;

    // Response codes carried in the first byte of a frame
    localparam logic [7:0] RSP_ACK    = 8'h40;
    localparam logic [7:0] RSP_BUTTON = 8'h41;
    localparam logic [7:0] RSP_POLL   = 8'h44;
    localparam logic [7:0] RSP_RESET  = 8'h46;
    localparam logic [7:0] RSP_ERROR  = 8'h77;

    // Command bytes
    localparam logic [7:0] CMD_INIT_0  = 8'hC3;
    localparam logic [7:0] CMD_INIT_1  = 8'hC8;
    localparam logic [7:0] CMD_INIT_2  = 8'hC2;
    localparam logic [7:0] CMD_SET_LED = 8'hC6;
    localparam logic [7:0] CMD_LED_ALL = 8'h0F;

    // Decimal point segment
    localparam logic [7:0] SEG_DP = 8'h10;

    // Pending-ack counts after a command goes out from an idle count
    localparam logic [2:0] ACKS_AFTER_INIT = 3'd4;
    localparam logic [2:0] ACKS_AFTER_LED  = 3'd1;

    // Byte positions inside a command burst
    localparam int         IDX_W           = 4;
    localparam logic [3:0] INIT_PREFIX_LEN = 4'd3;
    localparam logic [3:0] LED_HEAD_LEN    = 4'd2;
    localparam logic [3:0] LED_LAST_IDX    = 4'd5;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        JOB_NONE = 2'd0,
        JOB_LED  = 2'd1,
        JOB_INIT = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  rx_byte;
        logic [15:0] digits_hex;
        logic [3:0]  digit_enable;
        logic [3:0]  decimal_points;
    } req_word_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       last;
        logic       status;
        logic [7:0] buttons;
    } rsp_word_t;

    typedef struct packed {
        job_kind_t       kind;
        logic            status;
        logic [7:0]      buttons;
        logic [3:0][7:0] seg;
    } job_t;

    // Map one hex digit to its segment pattern
    function automatic logic [7:0] seg_of_hex(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'h0: s = 8'he7;
            4'h1: s = 8'h06;
            4'h2: s = 8'hcb;
            4'h3: s = 8'h8f;
            4'h4: s = 8'h2e;
            4'h5: s = 8'had;
            4'h6: s = 8'hed;
            4'h7: s = 8'h86;
            4'h8: s = 8'hef;
            4'h9: s = 8'hae;
            4'ha: s = 8'hee;
            4'hb: s = 8'h6d;
            4'hc: s = 8'he1;
            4'hd: s = 8'h4f;
            4'he: s = 8'he9;
            default: s = 8'he8;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/button_pad_link_controller.sv]
// Host side of the button-and-LED pad link. Each request word (a received
// link byte, an init request or a set-LED request) gives one to nine
// response words, one per cycle: a word with no byte to send, a six-byte
// set-LED burst, or the nine-byte init burst. Requests are accepted every
// cycle as long as the two-entry job queue between the request decoder and
// the byte sequencer has room, so the sustained rate is set by the
// sequencer's one byte per cycle. The response word sits in an output
// register; while it waits the sequencer holds, and the decoder keeps
// taking requests until the job queue fills.
`timescale 1ns / 1ps
`default_nettype none

module button_pad_link_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire bplc_pkg::req_word_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output bplc_pkg::rsp_word_t      rsp
);

    logic           push;
    logic           queue_full;
    logic           pop;
    logic           head_valid;
    bplc_pkg::job_t push_job;
    bplc_pkg::job_t head_job;

    bplc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    bplc_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    bplc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

[hw/rtl/bplc_job_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bplc_job_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire bplc_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output bplc_pkg::job_t      head_job
);

    bplc_pkg::job_t                     entry_reg [bplc_pkg::QUEUE_DEPTH];
    logic [bplc_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [bplc_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [bplc_pkg::QCNT_W-1:0]        count_reg, count_next;

    localparam logic [bplc_pkg::QPTR_W-1:0] PTR_LAST =
        bplc_pkg::QPTR_W'(bplc_pkg::QUEUE_DEPTH - 1);
    localparam logic [bplc_pkg::QCNT_W-1:0] CNT_FULL =
        bplc_pkg::QCNT_W'(bplc_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bplc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bplc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire bplc_pkg::req_word_t req,
    input  wire logic                queue_full,
    output logic                     push,
    output bplc_pkg::job_t           push_job
);

    logic [7:0]      win0_reg, win0_next;
    logic [7:0]      win1_reg, win1_next;
    logic [1:0]      fill_reg, fill_next;
    logic [2:0]      acks_reg, acks_next;
    logic            waiting_reg, waiting_next;
    logic [3:0][7:0] seg_reg, seg_next;
    logic [7:0]      buttons_reg, buttons_next;

    bplc_pkg::job_kind_t kind;
    logic                status;
    logic                frame;
    logic                do_ack;
    logic [2:0]          acks_dec;
    logic [7:0]          btn_decoded;
    logic [3:0][7:0]     seg_req;

    assign req_ready = !queue_full;
    assign push      = req_valid && req_ready;

    // Decode button bits from the two data bytes of a frame
    always_comb
    begin
        btn_decoded[3:0] = ~win1_reg[3:0];
        btn_decoded[4]   = ~req.rx_byte[0];
        btn_decoded[5]   = ~req.rx_byte[2];
        btn_decoded[6]   = ~req.rx_byte[1];
        btn_decoded[7]   = ~req.rx_byte[3];
    end

    // Build the segment image of a set-LED request
    always_comb
    begin
        logic [7:0] s;
        for (int k = 0; k < 4; k++)
        begin
            s = bplc_pkg::seg_of_hex(req.digits_hex[4*k +: 4]);
            if (!req.digit_enable[k])
            begin
                s = '0;
            end
            if (req.decimal_points[k])
            begin
                s = s | bplc_pkg::SEG_DP;
            end
            seg_req[k] = s;
        end
    end

    assign frame    = (fill_reg == 2'd2) && !win0_reg[7] && win1_reg[7] && req.rx_byte[7];
    assign acks_dec = (acks_reg != '0) ? acks_reg - 3'd1 : '0;

    // Classify the word and work out the next state
    always_comb
    begin
        win0_next    = win0_reg;
        win1_next    = win1_reg;
        fill_next    = fill_reg;
        acks_next    = acks_reg;
        waiting_next = waiting_reg;
        seg_next     = seg_reg;
        buttons_next = buttons_reg;
        kind         = bplc_pkg::JOB_NONE;
        status       = 1'b0;
        do_ack       = 1'b0;

        unique case (req.req_type)
            bplc_pkg::REQ_RX:
            begin
                if (fill_reg == 2'd0)
                begin
                    win0_next = req.rx_byte;
                    fill_next = 2'd1;
                end
                else if (fill_reg == 2'd1)
                begin
                    win1_next = req.rx_byte;
                    fill_next = 2'd2;
                end
                else if (frame)
                begin
                    fill_next = 2'd0;
                    unique case (win0_reg) inside
                        bplc_pkg::RSP_POLL:
                        begin
                            buttons_next = btn_decoded;
                            do_ack       = 1'b1;
                        end
                        bplc_pkg::RSP_BUTTON:
                        begin
                            buttons_next = btn_decoded;
                        end
                        bplc_pkg::RSP_RESET:
                        begin
                            acks_next    = bplc_pkg::ACKS_AFTER_INIT;
                            waiting_next = 1'b0;
                            kind         = bplc_pkg::JOB_INIT;
                        end
                        bplc_pkg::RSP_ACK, bplc_pkg::RSP_ERROR:
                        begin
                            do_ack = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    // Drop the oldest byte of a misaligned window
                    win0_next = win1_reg;
                    win1_next = req.rx_byte;
                    fill_next = 2'd2;
                end
            end
            bplc_pkg::REQ_INIT:
            begin
                if (acks_reg != '0)
                begin
                    status = 1'b1;
                end
                else
                begin
                    acks_next    = bplc_pkg::ACKS_AFTER_INIT;
                    waiting_next = 1'b0;
                    kind         = bplc_pkg::JOB_INIT;
                end
            end
            bplc_pkg::REQ_LED:
            begin
                seg_next = seg_req;
                if (acks_reg == '0)
                begin
                    acks_next    = bplc_pkg::ACKS_AFTER_LED;
                    waiting_next = 1'b0;
                    kind         = bplc_pkg::JOB_LED;
                end
                else
                begin
                    waiting_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Count down an ack and release a deferred set-LED
        if (do_ack)
        begin
            acks_next = acks_dec;
            if (acks_dec == '0 && waiting_reg)
            begin
                acks_next    = bplc_pkg::ACKS_AFTER_LED;
                waiting_next = 1'b0;
                kind         = bplc_pkg::JOB_LED;
            end
        end
    end

    // Hand the job to the back part
    always_comb
    begin
        push_job.kind    = kind;
        push_job.status  = status;
        push_job.buttons = buttons_next;
        push_job.seg     = seg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg    <= '0;
            win1_reg    <= '0;
            fill_reg    <= '0;
            acks_reg    <= '0;
            waiting_reg <= 1'b0;
            seg_reg     <= '0;
            buttons_reg <= '0;
        end
        else if (push)
        begin
            win0_reg    <= win0_next;
            win1_reg    <= win1_next;
            fill_reg    <= fill_next;
            acks_reg    <= acks_next;
            waiting_reg <= waiting_next;
            seg_reg     <= seg_next;
            buttons_reg <= buttons_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bplc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bplc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire bplc_pkg::job_t head_job,
    output logic                pop,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output bplc_pkg::rsp_word_t rsp
);

    logic [bplc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    bplc_pkg::rsp_word_t        out_reg;
    bplc_pkg::rsp_word_t        word;
    logic [bplc_pkg::IDX_W-1:0] led_idx;
    logic [bplc_pkg::IDX_W-1:0] seg_pos;
    logic                       load;

    assign rsp_valid = valid_reg;
    assign rsp       = out_reg;
    assign load      = head_valid && (!valid_reg || rsp_ready);
    assign pop       = load && word.last;

    // Pick the byte of the burst at the current position
    always_comb
    begin
        led_idx      = (head_job.kind == bplc_pkg::JOB_INIT)
                     ? idx_reg - bplc_pkg::INIT_PREFIX_LEN : idx_reg;
        seg_pos      = led_idx - bplc_pkg::LED_HEAD_LEN;
        word.status  = head_job.status;
        word.buttons = head_job.buttons;
        word.tx_byte = '0;
        word.tx_valid = 1'b0;
        word.last    = 1'b1;

        unique case (head_job.kind)
            bplc_pkg::JOB_LED, bplc_pkg::JOB_INIT:
            begin
                word.tx_valid = 1'b1;
                word.last     = (led_idx == bplc_pkg::LED_LAST_IDX);
                if (head_job.kind == bplc_pkg::JOB_INIT && idx_reg == 4'd0)
                begin
                    word.tx_byte = bplc_pkg::CMD_INIT_0;
                end
                else if (head_job.kind == bplc_pkg::JOB_INIT && idx_reg == 4'd1)
                begin
                    word.tx_byte = bplc_pkg::CMD_INIT_1;
                end
                else if (head_job.kind == bplc_pkg::JOB_INIT && idx_reg == 4'd2)
                begin
                    word.tx_byte = bplc_pkg::CMD_INIT_2;
                end
                else if (led_idx == 4'd0)
                begin
                    word.tx_byte = bplc_pkg::CMD_SET_LED;
                end
                else if (led_idx == 4'd1)
                begin
                    word.tx_byte = bplc_pkg::CMD_LED_ALL;
                end
                else
                begin
                    word.tx_byte = head_job.seg[seg_pos[1:0]];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Advance through the burst and hold the output word
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = word.last ? '0 : idx_reg + 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= word;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bplc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "button_pad_link_controller_macros.svh"

module bplc_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic                req_ready,
    input  wire bplc_pkg::req_word_t req,
    input  wire logic                rsp_valid,
    input  wire logic                rsp_ready,
    input  wire bplc_pkg::rsp_word_t rsp
);

    logic req_stall;
    logic rsp_stall;
    logic burst_step;
    logic empty_word_bad;

    assign req_stall      = req_valid && !req_ready;
    assign rsp_stall      = rsp_valid && !rsp_ready;
    assign burst_step     = rsp_valid && rsp_ready && !rsp.last;
    assign empty_word_bad = rsp_valid && !rsp.tx_valid && (!rsp.last || rsp.tx_byte != 8'h00);

    // Hold a stalled request word
    `BPLC_ASSERT(a_req_hold, req_stall |=> req_valid && $stable(req), "stalled request moved")

    // Hold a stalled response word
    `BPLC_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp), "stalled response moved")

    // A word with no byte closes its request
    `BPLC_NEVER(a_empty_word, empty_word_bad, "empty response word malformed")

    // A refused init sends nothing
    `BPLC_NEVER(a_refused_quiet, rsp_valid && rsp.status && rsp.tx_valid, "refused init sent")

    // Stream a burst without gaps
    `BPLC_ASSERT(a_burst_gapless, burst_step |=> rsp_valid, "gap inside a command burst")

endmodule

bind button_pad_link_controller bplc_checker u_bplc_checker (.*);

`default_nettype wire
